// File: design/min_clique_cover_search_core_macros.svh
// Assertion macros for the minimum clique cover search block.
// Included by the top level; no other dependencies.
`ifndef MIN_CLIQUE_COVER_SEARCH_CORE_MACROS_SVH
`define MIN_CLIQUE_COVER_SEARCH_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MCCS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mccs assertion failed");

// next-cycle implication, disabled in reset
`define MCCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mccs assertion failed");

`endif

// File: design/mccs_pkg.sv
// Package for the minimum clique cover search block: field widths,
// operation codes, controller states and control/status structs.
`default_nettype none

package mccs_pkg;

    localparam int OP_W  = 2;
    localparam int VTX_W = 4;
    localparam int CNT_W = 5;

    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic edge_wr;
        logic clear;
        logic start;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic finished;
    } t_sts;

endpackage

`default_nettype wire

// File: design/mccs_in_if.sv
// Input channel interface: valid/ready plus one command word.
// Depends on mccs_pkg for field widths.
`default_nettype none

interface mccs_in_if;
    logic                        valid;
    logic                        ready;
    logic [mccs_pkg::OP_W-1:0]   operation;
    logic [mccs_pkg::VTX_W-1:0]  vertex_a;
    logic [mccs_pkg::VTX_W-1:0]  vertex_b;

    modport source (output valid, output operation, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input operation, input vertex_a, input vertex_b,
                    output ready);
endinterface

`default_nettype wire

// File: design/mccs_out_if.sv
// Output channel interface: valid/ready plus the result word.
// Depends on mccs_pkg for field widths.
`default_nettype none

interface mccs_out_if;
    logic                        valid;
    logic                        ready;
    logic [mccs_pkg::CNT_W-1:0]  min_groups;

    modport source (output valid, output min_groups, input ready);
    modport sink   (input valid, input min_groups, output ready);
endinterface

`default_nettype wire

// File: design/mccs_ctrl.sv
// Controller state machine: input handshake, search sequencing, output valid.
// Depends on mccs_pkg.
`default_nettype none

module mccs_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [mccs_pkg::OP_W-1:0]  i_operation,
    output logic                            o_in_ready,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    input  wire mccs_pkg::t_sts             i_sts,
    output mccs_pkg::t_cmd                  o_cmd
);

    mccs_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mccs_pkg::S_IDLE: begin
                if (i_in_valid && i_operation == mccs_pkg::OP_SEARCH) n_state = mccs_pkg::S_SEARCH;
            end
            mccs_pkg::S_SEARCH: begin
                if (i_sts.finished) n_state = mccs_pkg::S_DONE;
            end
            mccs_pkg::S_DONE: begin
                if (w_out_free) n_state = mccs_pkg::S_IDLE;
            end
            default: n_state = mccs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mccs_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.edge_wr = i_in_valid && i_operation == mccs_pkg::OP_ADD_EDGE;
                o_cmd.clear   = i_in_valid && i_operation == mccs_pkg::OP_CLEAR;
                o_cmd.start   = i_in_valid && i_operation == mccs_pkg::OP_SEARCH;
            end
            mccs_pkg::S_SEARCH: begin
                o_cmd.step = 1'b1;
            end
            mccs_pkg::S_DONE: begin
                o_cmd.load_out = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mccs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: design/mccs_datapath.sv
// Datapath: adjacency matrix, vertex count register, depth-first partition
// search with per-depth choice stack, group masks and result register.
// Depends on mccs_pkg.
`default_nettype none

module mccs_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mccs_pkg::t_cmd              i_cmd,
    output mccs_pkg::t_sts                   o_sts,
    input  wire logic                        i_cfg_we,
    input  wire logic [mccs_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  wire logic [mccs_pkg::VTX_W-1:0]  i_vertex_a,
    input  wire logic [mccs_pkg::VTX_W-1:0]  i_vertex_b,
    output logic [mccs_pkg::CNT_W-1:0]       o_min_groups
);

    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam int GW = $clog2(MAX_VERTICES);

    logic [mccs_pkg::CNT_W-1:0] r_num_vertices;
    logic [MAX_VERTICES-1:0]    r_adj     [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]    r_members [MAX_VERTICES];
    logic [GW-1:0]              r_choice  [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]    r_opened;
    logic [DW-1:0]              r_depth, r_trial, r_open, r_best, r_n;
    logic [mccs_pkg::CNT_W-1:0] r_result;

    logic [GW-1:0] w_d_ix, w_g_ix, w_dm1_ix, w_c;
    logic [DW-1:0] w_dm1, w_n_sat;
    logic          w_fit, w_prune, w_leaf;
    logic          w_place, w_new, w_skip, w_back;
    logic          w_edge_ok;

    assign w_d_ix   = r_depth[GW-1:0];
    assign w_g_ix   = r_trial[GW-1:0];
    assign w_dm1    = r_depth - 1'b1;
    assign w_dm1_ix = w_dm1[GW-1:0];
    assign w_c      = r_choice[w_dm1_ix];
    assign w_n_sat  = (32'(r_num_vertices) > MAX_VERTICES) ? DW'(MAX_VERTICES)
                                                           : DW'(r_num_vertices);
    assign w_edge_ok = (32'(i_vertex_a) < MAX_VERTICES) && (32'(i_vertex_b) < MAX_VERTICES);

    // vertex joins group g only if every current member is adjacent to it
    assign w_fit   = (r_members[w_g_ix] & ~r_adj[w_d_ix]) == '0;
    assign w_prune = r_open >= r_best;
    assign w_leaf  = r_depth == r_n;

    // opening a new group is the last choice at a depth, tried once
    always_comb begin
        w_place = 1'b0;
        w_new   = 1'b0;
        w_skip  = 1'b0;
        w_back  = 1'b0;
        if (w_prune || w_leaf) begin
            w_back = 1'b1;
        end else if (r_trial < r_open) begin
            if (w_fit) w_place = 1'b1;
            else w_skip = 1'b1;
        end else if (r_trial == r_open && r_open + 1'b1 < r_best) begin
            w_place = 1'b1;
            w_new   = 1'b1;
        end else begin
            w_back = 1'b1;
        end
    end

    assign o_sts.finished = i_cmd.step && w_back && r_depth == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= '0;
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_adj[i]     <= '0;
                r_members[i] <= '0;
            end
            r_depth <= '0;
            r_trial <= '0;
            r_open  <= '0;
            r_best  <= '0;
            r_n     <= '0;
        end else begin
            if (i_cfg_we) r_num_vertices <= i_cfg_wdata;
            if (i_cmd.clear) begin
                for (int i = 0; i < MAX_VERTICES; i++) r_adj[i] <= '0;
            end else if (i_cmd.edge_wr && w_edge_ok) begin
                r_adj[GW'(i_vertex_a)][GW'(i_vertex_b)] <= 1'b1;
                r_adj[GW'(i_vertex_b)][GW'(i_vertex_a)] <= 1'b1;
            end
            if (i_cmd.start) begin
                r_depth <= '0;
                r_trial <= '0;
                r_open  <= '0;
                r_best  <= w_n_sat;
                r_n     <= w_n_sat;
            end else if (i_cmd.step) begin
                if (w_place) begin
                    r_choice[w_d_ix]          <= w_g_ix;
                    r_opened[w_d_ix]          <= w_new;
                    r_members[w_g_ix][w_d_ix] <= 1'b1;
                    if (w_new) r_open <= r_open + 1'b1;
                    r_depth <= r_depth + 1'b1;
                    r_trial <= '0;
                end else if (w_skip) begin
                    r_trial <= r_trial + 1'b1;
                end else if (r_depth != '0) begin
                    if (!w_prune && w_leaf) r_best <= r_open;
                    r_members[w_c][w_dm1_ix] <= 1'b0;
                    if (r_opened[w_dm1_ix]) r_open <= r_open - 1'b1;
                    r_depth <= w_dm1;
                    r_trial <= DW'(w_c) + 1'b1;
                end else if (!w_prune && w_leaf) begin
                    r_best <= r_open;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) r_result <= mccs_pkg::CNT_W'(r_best);
    end

    assign o_min_groups = r_result;

endmodule

`default_nettype wire

// File: design/min_clique_cover_search_core.sv
// Minimum clique cover search block, top level.
// Input channel i_in (valid/ready): each word carries operation, vertex_a, vertex_b.
//   add edge and clear graph words are accepted one per cycle while the block is idle.
//   run search produces one word on o_out with min_groups.
// i_cfg_we/i_cfg_wdata write the vertex count (saturated to MAX_VERTICES); write
// only while the block is idle.
// A search walks set partitions depth first, one step per cycle on the shared
// group-mask and choice stack, bounded by pruning against the best count so far;
// the result is then loaded into the output register once that register is free.
// i_in.ready is low during a search.
// The result sits in an output register; a stalled receiver holds o_out.valid and
// the block keeps taking edge and clear words. A following search runs, then waits
// until the pending result is taken.
// Synchronous active-low reset clears the graph, the vertex count and both channels.
`default_nettype none
`include "min_clique_cover_search_core_macros.svh"

module min_clique_cover_search_core #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [mccs_pkg::CNT_W-1:0]  i_cfg_wdata,
    mccs_in_if.sink                          i_in,
    mccs_out_if.source                       o_out
);

    mccs_pkg::t_cmd w_cmd;
    mccs_pkg::t_sts w_sts;

    mccs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mccs_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_vertex_a   (i_in.vertex_a),
        .i_vertex_b   (i_in.vertex_b),
        .o_min_groups (o_out.min_groups)
    );

    `MCCS_ASSERT_NOW(a_no_accept_in_search, i_clk, i_rst_n, w_cmd.step, !i_in.ready)
    `MCCS_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, w_cmd.load_out, o_out.valid)
    `MCCS_ASSERT_NEXT(a_finish_stops, i_clk, i_rst_n, w_sts.finished, !w_cmd.step)

endmodule

`default_nettype wire

// File: verif/mccs_scoreboard.sv
// Scoreboard for the minimum clique cover search block: predicts min_groups
// for each accepted search word and checks results in order. Depends on mccs_pkg.
`default_nettype none

package mccs_scoreboard_pkg;

    class clique_cover_scoreboard;
        logic [15:0] adj_rows [16];
        logic [15:0] members [16];
        int unsigned active_n;
        int unsigned best;
        logic [mccs_pkg::CNT_W-1:0] num_vertices;
        logic [mccs_pkg::CNT_W-1:0] pending_groups [$];
        int unsigned fail_count;

        function new();
            foreach (adj_rows[i]) adj_rows[i] = '0;
            num_vertices = '0;
            fail_count = 0;
        endfunction

        function void set_num_vertices(logic [mccs_pkg::CNT_W-1:0] v);
            num_vertices = v;
        endfunction

        function void explore(int unsigned depth, int unsigned open);
            logic [15:0] bitm;
            if (open >= best) return;
            if (depth >= active_n) begin
                best = open;
                return;
            end
            bitm = 16'(1) << depth;
            for (int unsigned g = 0; g < open; g++) begin
                if ((members[g] & ~adj_rows[depth]) == '0) begin
                    members[g] |= bitm;
                    explore(depth + 1, open);
                    members[g] &= ~bitm;
                end
            end
            if (open + 1 < best && open < 16) begin
                members[open] = bitm;
                explore(depth + 1, open + 1);
                members[open] = '0;
            end
        endfunction

        function void note_word(logic [mccs_pkg::OP_W-1:0] op,
                                logic [mccs_pkg::VTX_W-1:0] a,
                                logic [mccs_pkg::VTX_W-1:0] b);
            if (op == mccs_pkg::OP_ADD_EDGE) begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
            end else if (op == mccs_pkg::OP_CLEAR) begin
                foreach (adj_rows[i]) adj_rows[i] = '0;
            end else if (op == mccs_pkg::OP_SEARCH) begin
                active_n = (num_vertices > 16) ? 16 : num_vertices;
                foreach (members[i]) members[i] = '0;
                best = active_n;
                explore(0, 0);
                pending_groups.push_back(mccs_pkg::CNT_W'(best));
            end
        endfunction

        function void check_result(logic [mccs_pkg::CNT_W-1:0] got);
            logic [mccs_pkg::CNT_W-1:0] want;
            if (pending_groups.size() == 0) begin
                $error("unexpected result word: min_groups actual %0d", got);
                fail_count++;
                return;
            end
            want = pending_groups.pop_front();
            if (got !== want) begin
                $error("min_groups mismatch: expected %0d actual %0d", want, got);
                fail_count++;
            end
        endfunction
    endclass
endpackage

`default_nettype wire

// File: verif/tb.sv
// Top-level testbench for min_clique_cover_search_core: directed and random
// command words with bursty sender and stalling receiver. Depends on mccs_pkg,
// the channel interfaces and mccs_scoreboard_pkg.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [mccs_pkg::CNT_W-1:0] i_cfg_wdata = '0;

    mccs_in_if  cmd_ch ();
    mccs_out_if res_ch ();

    min_clique_cover_search_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_in(cmd_ch.sink), .o_out(res_ch.source)
    );

    mccs_scoreboard_pkg::clique_cover_scoreboard cover_sb;
    int unsigned idle_cycles = 0;
    int unsigned stall_phase = 0;
    int unsigned stall_mode = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.operation = mccs_pkg::OP_ADD_EDGE;
        cmd_ch.vertex_a = '0;
        cmd_ch.vertex_b = '0;
        res_ch.ready = 1'b0;
    end

    // sample on rising edge; watchdog counts cycles with no handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready)
                cover_sb.note_word(cmd_ch.operation, cmd_ch.vertex_a, cmd_ch.vertex_b);
            if (res_ch.valid && res_ch.ready)
                cover_sb.check_result(res_ch.min_groups);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver stall pattern: periodic or random stalls with mode changes, some stretches always ready
    always @(negedge i_clk) begin
        stall_phase++;
        if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= (stall_phase % 3) != 0;
            2: res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= (stall_phase % 11) > 6;
        endcase
    end

    task automatic send_word(logic [mccs_pkg::OP_W-1:0] op, logic [mccs_pkg::VTX_W-1:0] a,
                             logic [mccs_pkg::VTX_W-1:0] b);
        cmd_ch.valid <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.vertex_a <= a;
        cmd_ch.vertex_b <= b;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int unsigned n);
        cmd_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // wait for all results, then margin for a trailing word in flight
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (cover_sb.pending_groups.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_num_vertices(logic [mccs_pkg::CNT_W-1:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cover_sb.set_num_vertices(v);
    endtask

    task automatic send_random_word(int unsigned nv);
        int unsigned r;
        logic [mccs_pkg::OP_W-1:0] op;
        r = $urandom_range(0, 99);
        if (r < 80) op = mccs_pkg::OP_ADD_EDGE;
        else if (r < 86) op = mccs_pkg::OP_CLEAR;
        else if (r < 97) op = mccs_pkg::OP_SEARCH;
        else op = mccs_pkg::OP_UNUSED;
        if ($urandom_range(0, 9) == 0 || nv == 0)
            send_word(op, mccs_pkg::VTX_W'($urandom), mccs_pkg::VTX_W'($urandom));
        else
            send_word(op, mccs_pkg::VTX_W'($urandom_range(0, nv - 1)),
                      mccs_pkg::VTX_W'($urandom_range(0, nv - 1)));
    endtask

    initial begin
        int unsigned burst;
        int unsigned nv;
        logic [mccs_pkg::CNT_W-1:0] cfg_choices [6];
        cfg_choices = '{5'd16, 5'd1, 5'd31, 5'd8, 5'd12, 5'd10};
        cover_sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty graph and default vertex count
        send_word(mccs_pkg::OP_SEARCH, 4'd0, 4'd0);
        write_num_vertices(5'd0);
        send_word(mccs_pkg::OP_SEARCH, 4'd15, 4'd15);
        write_num_vertices(5'd4);
        send_word(mccs_pkg::OP_SEARCH, 4'd0, 4'd0);
        send_word(mccs_pkg::OP_ADD_EDGE, 4'd0, 4'd1);
        send_word(mccs_pkg::OP_ADD_EDGE, 4'd2, 4'd2);
        send_word(mccs_pkg::OP_ADD_EDGE, 4'd15, 4'd3);
        send_word(mccs_pkg::OP_UNUSED, 4'd1, 4'd2);
        send_word(mccs_pkg::OP_SEARCH, 4'd0, 4'd0);
        send_word(mccs_pkg::OP_ADD_EDGE, 4'd1, 4'd2);
        send_word(mccs_pkg::OP_ADD_EDGE, 4'd0, 4'd2);
        send_word(mccs_pkg::OP_ADD_EDGE, 4'd3, 4'd2);
        send_word(mccs_pkg::OP_SEARCH, 4'd0, 4'd0);
        send_word(mccs_pkg::OP_CLEAR, 4'd0, 4'd0);
        send_word(mccs_pkg::OP_SEARCH, 4'd0, 4'd0);
        write_num_vertices(5'd31);
        for (int i = 0; i < 15; i++) send_word(mccs_pkg::OP_ADD_EDGE, 4'(i), 4'(i + 1));
        send_word(mccs_pkg::OP_SEARCH, 4'd0, 4'd0);
        write_num_vertices(5'd16);
        send_word(mccs_pkg::OP_SEARCH, 4'd0, 4'd0);

        for (int ph = 0; ph < 6; ph++) begin
            write_num_vertices(cfg_choices[ph]);
            nv = (cfg_choices[ph] > 16) ? 16 : cfg_choices[ph];
            send_word(mccs_pkg::OP_CLEAR, 4'd0, 4'd0);
            for (int k = 0; k < 250; ) begin
                burst = $urandom_range(1, 12);
                for (int j = 0; j < burst; j++) begin
                    send_random_word(nv);
                    k++;
                end
                if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 6));
                if (k > 120 && k < 135 && cover_sb.pending_groups.size() != 0) begin
                    cmd_ch.valid <= 1'b0;
                    while (cover_sb.pending_groups.size() != 0) @(negedge i_clk);
                end
            end
        end

        drain_results();
        if (cover_sb.fail_count == 0 && cover_sb.pending_groups.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
